@@ src/gpio_rb_pkg.sv @@
// Shared constants for the GPIO register block: pin count, stream field layout,
// register word offsets and access codes. No dependencies.

package gpio_rb_pkg;

  // Pin count, 32 to 60
  localparam int NumPins = 60;

  // Fixed field widths
  localparam int CmdW    = 1;
  localparam int OffW    = 6;
  localparam int DataW   = 32;
  localparam int PinBusW = 60;

  // Slave stream tdata: word_offset, write_data, pin_levels, padded to bytes
  localparam int InOffLsb  = 0;
  localparam int InDataLsb = InOffLsb + OffW;
  localparam int InLvlLsb  = InDataLsb + DataW;
  localparam int InUsedW   = InLvlLsb + PinBusW;
  localparam int InTdataW  = ((InUsedW + 7) / 8) * 8;

  // Master stream tdata: read_data, drive_levels, drive_enables, pull up, pull down
  localparam int OutTdataW = DataW + 4 * PinBusW;

  // Function-select words: ten 3-bit fields each
  localparam int FselFieldW = 3;
  localparam int FselPerWord = 10;
  localparam int FselBitsW  = FselFieldW * FselPerWord;
  localparam int FselWords  = (NumPins + FselPerWord - 1) / FselPerWord;
  localparam int FselIdxW   = $clog2(FselWords);

  localparam logic [FselFieldW-1:0] FselOutput = 3'd1;

  // Access kinds
  localparam logic [CmdW-1:0] CmdRead  = 1'b0;
  localparam logic [CmdW-1:0] CmdWrite = 1'b1;

  // Register word offsets
  localparam logic [OffW-1:0] OffFsel0    = 6'd0;
  localparam logic [OffW-1:0] OffFselLast = 6'd5;
  localparam logic [OffW-1:0] OffSet0     = 6'd7;
  localparam logic [OffW-1:0] OffSet1     = 6'd8;
  localparam logic [OffW-1:0] OffClr0     = 6'd10;
  localparam logic [OffW-1:0] OffClr1     = 6'd11;
  localparam logic [OffW-1:0] OffLev0     = 6'd13;
  localparam logic [OffW-1:0] OffLev1     = 6'd14;
  localparam logic [OffW-1:0] OffPull     = 6'd37;
  localparam logic [OffW-1:0] OffPullClk0 = 6'd38;
  localparam logic [OffW-1:0] OffPullClk1 = 6'd39;

  // Pull codes
  localparam logic [1:0] PullDown = 2'd1;
  localparam logic [1:0] PullUp   = 2'd2;

  // Field bits of a function-select word that belong to existing pins
  function automatic logic [FselBitsW-1:0] fsel_mask(input logic [FselIdxW-1:0] w);
    logic [FselBitsW-1:0] m;
    m = '0;
    for (int i = 0; i < FselPerWord; i++) begin
      if (int'(w) * FselPerWord + i < NumPins) begin
        m[i*FselFieldW +: FselFieldW] = '1;
      end
    end
    return m;
  endfunction

endpackage

@@ src/gpio_register_block_core.sv @@
// GPIO register block: word-addressed function select, output latch, level and
// pull registers behind a stream interface. Depends on gpio_rb_pkg.
//
// Usage: each slave-stream transfer is one 32-bit bus access. tuser carries the
// access kind (read or write); tdata carries the word offset, the write data and
// the sampled pin levels. Every access yields exactly one master-stream transfer
// holding the read word (zero for writes and write-only words) together with
// the output latch, output-enable and pull masks as they stand after the access.
// The result is valid in the cycle after the slave transfer, and while the
// receiver takes results an access can be taken every cycle: the single result
// register is refilled in the same cycle it is drained. Register state updates
// when the access is taken. Reset clears all function selects, the output latch,
// the pull code and the latched pulls, and empties the result register. While
// the receiver stalls, the held result keeps its value and s_axis_tready_o falls,
// so no access is taken until the result has gone.

module gpio_register_block_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // [5:0] word_offset, [37:6] write_data, [97:38] pin_levels, rest zero
  input  logic [gpio_rb_pkg::InTdataW-1:0]  s_axis_tdata_i,
  // [0] command
  input  logic [gpio_rb_pkg::CmdW-1:0]      s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [31:0] read_data, [91:32] drive_levels, [151:92] drive_enables,
  // [211:152] pull_up_mask, [271:212] pull_down_mask
  output logic [gpio_rb_pkg::OutTdataW-1:0] m_axis_tdata_o
);
  import gpio_rb_pkg::*;

  logic                 in_fire;
  logic [OffW-1:0]      word;
  logic [DataW-1:0]     data;
  logic [PinBusW-1:0]   levels;
  logic [63:0]          lo_wide;
  logic [63:0]          hi_wide;
  logic [63:0]          lvl_wide;
  logic [FselIdxW-1:0]  fsel_idx;
  logic                 fsel_hit;

  logic [FselBitsW-1:0] fsel_q [FselWords];
  logic [FselBitsW-1:0] fsel_d [FselWords];
  logic [NumPins-1:0]   latch_q, latch_d;
  logic [1:0]           pull_ctl_q, pull_ctl_d;
  logic [NumPins-1:0]   up_q, up_d;
  logic [NumPins-1:0]   dn_q, dn_d;
  logic [NumPins-1:0]   en;
  logic [DataW-1:0]     rd;

  logic                 out_valid_q;
  logic [OutTdataW-1:0] out_data_q;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  assign word     = s_axis_tdata_i[InOffLsb +: OffW];
  assign data     = s_axis_tdata_i[InDataLsb +: DataW];
  assign levels   = s_axis_tdata_i[InLvlLsb +: PinBusW];
  assign lo_wide  = {32'b0, data};
  assign hi_wide  = {data, 32'b0};
  assign lvl_wide = {{(64 - NumPins){1'b0}}, levels[NumPins-1:0]};
  assign fsel_idx = word[FselIdxW-1:0];
  assign fsel_hit = int'(word) < FselWords;

  always_comb begin
    fsel_d     = fsel_q;
    latch_d    = latch_q;
    pull_ctl_d = pull_ctl_q;
    up_d       = up_q;
    dn_d       = dn_q;
    rd         = '0;
    if (s_axis_tuser_i == CmdWrite) begin
      unique case (word) inside
        [OffFsel0:OffFselLast]: begin
          if (fsel_hit) begin
            fsel_d[fsel_idx] = data[FselBitsW-1:0] & fsel_mask(fsel_idx);
          end
        end
        OffSet0:     latch_d = latch_q | lo_wide[NumPins-1:0];
        OffSet1:     latch_d = latch_q | hi_wide[NumPins-1:0];
        OffClr0:     latch_d = latch_q & ~lo_wide[NumPins-1:0];
        OffClr1:     latch_d = latch_q & ~hi_wide[NumPins-1:0];
        OffPull:     pull_ctl_d = data[1:0];
        OffPullClk0: begin
          up_d = (up_q & ~lo_wide[NumPins-1:0])
               | (lo_wide[NumPins-1:0] & {NumPins{pull_ctl_q == PullUp}});
          dn_d = (dn_q & ~lo_wide[NumPins-1:0])
               | (lo_wide[NumPins-1:0] & {NumPins{pull_ctl_q == PullDown}});
        end
        OffPullClk1: begin
          up_d = (up_q & ~hi_wide[NumPins-1:0])
               | (hi_wide[NumPins-1:0] & {NumPins{pull_ctl_q == PullUp}});
          dn_d = (dn_q & ~hi_wide[NumPins-1:0])
               | (hi_wide[NumPins-1:0] & {NumPins{pull_ctl_q == PullDown}});
        end
        default: ;
      endcase
    end else begin
      unique case (word) inside
        [OffFsel0:OffFselLast]: begin
          if (fsel_hit) begin
            rd = DataW'(fsel_q[fsel_idx]);
          end
        end
        OffLev0: rd = lvl_wide[31:0];
        OffLev1: rd = lvl_wide[63:32];
        OffPull: rd = {30'b0, pull_ctl_q};
        default: ;
      endcase
    end
  end

  // Output enables follow the function selects after this access
  always_comb begin
    for (int p = 0; p < NumPins; p++) begin
      en[p] = fsel_d[p / FselPerWord][(p % FselPerWord) * FselFieldW +: FselFieldW]
              == FselOutput;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < FselWords; w++) begin
        fsel_q[w] <= '0;
      end
      latch_q    <= '0;
      pull_ctl_q <= '0;
      up_q       <= '0;
      dn_q       <= '0;
    end else if (in_fire) begin
      fsel_q     <= fsel_d;
      latch_q    <= latch_d;
      pull_ctl_q <= pull_ctl_d;
      up_q       <= up_d;
      dn_q       <= dn_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      out_valid_q <= s_axis_tvalid_i;
    end
  end

  // Hold the result while the receiver stalls
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= {PinBusW'(dn_d), PinBusW'(up_d), PinBusW'(en),
                     PinBusW'(latch_d), rd};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

@@ src/gpio_rb_checker.sv @@
// Port-level checks for the GPIO register block and the bind that attaches them.
// Depends on gpio_rb_pkg and gpio_register_block_core.

module gpio_rb_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid_i,
  input logic                              s_axis_tready_o,
  input logic [gpio_rb_pkg::CmdW-1:0]      s_axis_tuser_i,
  input logic                              m_axis_tvalid_o,
  input logic                              m_axis_tready_i,
  input logic [gpio_rb_pkg::OutTdataW-1:0] m_axis_tdata_o
);
  import gpio_rb_pkg::*;

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its value
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // Every taken access shows its result in the next cycle
  a_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> m_axis_tvalid_o)
    else $error("no result after access");

  // Input side is ready whenever the result register is free or draining
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o == (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("ready does not follow result register");

  // A write never returns read data
  a_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i == CmdWrite
    |=> m_axis_tdata_o[DataW-1:0] == '0)
    else $error("write returned nonzero read data");

endmodule

bind gpio_register_block_core gpio_rb_checker u_gpio_rb_checker (.*);
